/* design/keyframe_color_ramp_macros.svh */
// Assertion macros shared by the keyframe color ramp design files.
// KFR_ASSERT_ON checks a property at every clock edge outside reset.
// KFR_ASSERT_NEXT checks that a condition is followed in the next cycle by another.
`ifndef KEYFRAME_COLOR_RAMP_MACROS_SVH
`define KEYFRAME_COLOR_RAMP_MACROS_SVH
`ifndef ASSERT_OFF
`define KFR_ASSERT_ON(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("keyframe_color_ramp assertion failed");
`define KFR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyframe_color_ramp assertion failed");
`else
`define KFR_ASSERT_ON(name, clk, rst, prop)
`define KFR_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

/* design/kfr_pkg.sv */
package kfr_pkg;

   localparam int TIME_W      = 16;
   localparam int CH_W        = 8;
   localparam int NUM_CH      = 4;
   localparam int COLOR_W     = CH_W * NUM_CH;
   localparam int SLOT_W      = 7;
   localparam int PCT_W       = 7;
   localparam int KEY_W       = 8;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int LSTART_W    = 7;
   localparam int LEND_W      = 8;

   localparam int REM_STEPS   = TIME_W;
   localparam int REM_CNT_W   = $clog2(REM_STEPS);
   localparam int BLEND_STEPS = CH_W + 1;
   localparam int BLEND_CNT_W = $clog2(BLEND_STEPS);
   localparam int ACC_W       = 2 * CH_W;

   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COLOR_W-1:0]  color_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_EMPTY_SPAN = 2'd1;
   localparam status_type ST_RANGE      = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PERCENT_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_ENABLE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_START   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_END     = 2'd3;

   localparam logic [PCT_W-1:0]  PCT_FULL       = 7'd100;
   localparam logic [LEND_W-1:0] LOOP_END_RESET = 8'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIVIDE,
      S_FETCH,
      S_FETCH_HI,
      S_LOAD,
      S_BLEND,
      S_DONE
   } state_type;

endpackage

/* design/kfr_if.sv */
interface kfr_req_if;
   import kfr_pkg::*;
   logic                valid;
   logic                ready;
   logic                opcode;
   logic [SLOT_W-1:0]   key_slot;
   logic [CH_W-1:0]     key_red;
   logic [CH_W-1:0]     key_green;
   logic [CH_W-1:0]     key_blue;
   logic [CH_W-1:0]     key_alpha;
   logic [TIME_W-1:0]   emitter_time;
   logic [PCT_W-1:0]    life_percent;
   logic [CH_W-1:0]     life_fraction;

   modport source (
      output valid, opcode, key_slot, key_red, key_green, key_blue, key_alpha,
             emitter_time, life_percent, life_fraction,
      input  ready
   );
   modport sink (
      input  valid, opcode, key_slot, key_red, key_green, key_blue, key_alpha,
             emitter_time, life_percent, life_fraction,
      output ready
   );
endinterface

interface kfr_rsp_if;
   import kfr_pkg::*;
   logic                valid;
   logic                ready;
   logic [CH_W-1:0]     out_red;
   logic [CH_W-1:0]     out_green;
   logic [CH_W-1:0]     out_blue;
   logic [CH_W-1:0]     out_alpha;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, out_red, out_green, out_blue, out_alpha, status,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, out_alpha, status,
      output ready
   );
endinterface

interface kfr_csr_if;
   import kfr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/keyframe_color_ramp.sv */
// Keyframe color ramp: a table of KEY_COUNT RGBA key colors with a lookup
// that either indexes by emitter time (wrapping or clamping) or blends two
// neighboring keys by lifetime percent.
// The req channel takes one word per item: opcode 0 writes a key color into
// key_slot, opcode 1 queries a color. Every item yields exactly one rsp word;
// a write answers black with status 0.
// The csr channel writes percent_mode, loop_enable, loop_start and loop_end
// by register index; it is always ready and should only be used while idle.
// From acceptance to the rsp word, a write or an early error goes straight
// to the done state; a direct key lookup fetches one key through the single
// key table read port, a percent blend fetches two and then runs the 9-step
// serial blend unit, and a wrapped time lookup first runs the 16-step serial
// remainder unit and then fetches one key if that key is in range.
// One item is in flight at a time; the next word is accepted the cycle after
// the previous result moves into the output register. A stalled receiver
// holds the output register and, behind it, one finished result, and req
// waits.
// Reset (synchronous, active high) clears the control state and sets the
// registers to 0, 0, 0 and 1. The key table is not cleared: a key that was
// never written reads as an unknown color.
`include "keyframe_color_ramp_macros.svh"

module keyframe_color_ramp #(
   parameter int KEY_COUNT = 128
) (
   input  logic       clock,
   input  logic       reset,
   kfr_req_if.sink    req_bus,
   kfr_rsp_if.source  rsp_bus,
   kfr_csr_if.sink    csr_bus
);
   import kfr_pkg::*;

   localparam int IDX_W = $clog2(KEY_COUNT);

   // Configuration registers.
   logic                pct_mode_ff;
   logic                loop_en_ff;
   logic [LSTART_W-1:0] loop_start_ff;
   logic [LEND_W-1:0]   loop_end_ff;

   // Sequencer and item context.
   state_type           state_ff, state_in;
   logic                blend_ff, blend_in;
   logic [CH_W-1:0]     frac_ff, frac_in;
   logic [IDX_W-1:0]    addr_ff, addr_in;
   color_type           k0_ff, k0_in;
   color_type           result_ff, result_in;
   status_type          status_ff, status_in;

   // Key table with one write port and one registered read port.
   color_type           key_mem_ff [KEY_COUNT];
   color_type           rd_data_ff;

   // Output register.
   logic                rsp_valid_ff;
   color_type           rsp_color_ff;
   status_type          rsp_status_ff;

   // Handshake and unit control.
   logic                req_accept;
   logic                csr_write;
   logic                mem_write;
   logic                out_free;
   logic                rsp_load;
   logic                rem_start;
   logic                rem_done;
   logic [KEY_W-1:0]    rem_value;
   logic                blend_start;
   logic                blend_done;
   color_type           blend_color;

   // Decode of an arriving item.
   state_type           launch_state;
   status_type          launch_status;
   logic [KEY_W-1:0]    launch_key;
   logic                launch_blend;
   logic                time_past_end;
   logic                span_empty;
   logic [KEY_W-1:0]    time_key;
   logic                time_key_ok;
   logic [KEY_W-1:0]    span;
   logic [TIME_W-1:0]   dividend;
   logic [KEY_W-1:0]    div_key;
   logic                div_key_ok;

   assign req_accept = req_bus.valid && req_bus.ready;
   assign csr_write  = csr_bus.valid && csr_bus.ready;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign mem_write  = req_accept && (req_bus.opcode == OP_WRITE)
                       && (32'(req_bus.key_slot) < 32'(KEY_COUNT));

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pct_mode_ff   <= 1'b0;
         loop_en_ff    <= 1'b0;
         loop_start_ff <= '0;
         loop_end_ff   <= LOOP_END_RESET;
      end else if (csr_write) begin
         unique case (csr_bus.index)
            CSR_PERCENT_MODE: pct_mode_ff   <= csr_bus.data[0];
            CSR_LOOP_ENABLE:  loop_en_ff    <= csr_bus.data[0];
            CSR_LOOP_START:   loop_start_ff <= csr_bus.data[LSTART_W-1:0];
            CSR_LOOP_END:     loop_end_ff   <= csr_bus.data[LEND_W-1:0];
            default: ;
         endcase
      end
   end

   // In time mode a wrap happens only at or past loop_end. Below it, and in
   // clamp mode, the key is the time itself or loop_end minus one, so it
   // always fits in KEY_W bits.
   always_comb begin
      time_past_end = req_bus.emitter_time >= {{(TIME_W-LEND_W){1'b0}}, loop_end_ff};
      span_empty    = {1'b0, loop_start_ff} >= loop_end_ff;
      span          = loop_end_ff - {1'b0, loop_start_ff};
      dividend      = req_bus.emitter_time - {{(TIME_W-LSTART_W){1'b0}}, loop_start_ff};
      if (loop_en_ff || !time_past_end) begin
         time_key = req_bus.emitter_time[KEY_W-1:0];
      end else begin
         time_key = loop_end_ff - 1'b1;
      end
      // Clamping with loop_end at zero gives index minus one: out of range.
      time_key_ok = (loop_en_ff || (loop_end_ff != '0))
                    && (32'(time_key) < 32'(KEY_COUNT));
   end

   always_comb begin
      launch_state  = S_DONE;
      launch_status = ST_OK;
      launch_key    = '0;
      launch_blend  = 1'b0;
      if (req_bus.opcode == OP_QUERY) begin
         if (!pct_mode_ff) begin
            if (loop_en_ff && time_past_end) begin
               if (span_empty) begin
                  launch_status = ST_EMPTY_SPAN;
               end else begin
                  launch_state = S_DIVIDE;
               end
            end else if (time_key_ok) begin
               launch_state = S_FETCH;
               launch_key   = time_key;
            end else begin
               launch_status = ST_RANGE;
            end
         end else if (req_bus.life_percent == PCT_FULL) begin
            // Full lifetime picks the last percent key without blending.
            launch_state = S_FETCH;
            launch_key   = {1'b0, PCT_FULL};
         end else if ((32'(req_bus.life_percent) + 32'd1) < 32'(KEY_COUNT)) begin
            launch_state = S_FETCH;
            launch_key   = {1'b0, req_bus.life_percent};
            launch_blend = 1'b1;
         end else begin
            launch_status = ST_RANGE;
         end
      end
   end

   assign div_key    = rem_value + {1'b0, loop_start_ff};
   assign div_key_ok = 32'(div_key) < 32'(KEY_COUNT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) state_in = launch_state;
         end
         S_DIVIDE: begin
            if (rem_done) state_in = div_key_ok ? S_FETCH : S_DONE;
         end
         S_FETCH:    state_in = blend_ff ? S_FETCH_HI : S_LOAD;
         S_FETCH_HI: state_in = S_LOAD;
         S_LOAD:     state_in = blend_ff ? S_BLEND : S_DONE;
         S_BLEND: begin
            if (blend_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_bus.ready = 1'b0;
      rem_start     = 1'b0;
      blend_start   = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_bus.ready = 1'b1;
            rem_start     = req_bus.valid && (launch_state == S_DIVIDE);
         end
         S_LOAD:  blend_start = blend_ff;
         S_DONE:  rsp_load    = out_free;
         default: ;
      endcase
   end

   // Item context updates.
   always_comb begin
      blend_in  = blend_ff;
      frac_in   = frac_ff;
      addr_in   = addr_ff;
      k0_in     = k0_ff;
      result_in = result_ff;
      status_in = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               blend_in  = launch_blend;
               frac_in   = req_bus.life_fraction;
               addr_in   = IDX_W'(launch_key);
               result_in = '0;
               status_in = launch_status;
            end
         end
         S_DIVIDE: begin
            if (rem_done) begin
               addr_in = IDX_W'(div_key);
               if (!div_key_ok) status_in = ST_RANGE;
            end
         end
         S_FETCH: begin
            if (blend_ff) addr_in = addr_ff + 1'b1;
         end
         S_FETCH_HI: k0_in = rd_data_ff;
         S_LOAD: begin
            if (!blend_ff) result_in = rd_data_ff;
         end
         S_BLEND: begin
            if (blend_done) result_in = blend_color;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      blend_ff  <= blend_in;
      frac_ff   <= frac_in;
      addr_ff   <= addr_in;
      k0_ff     <= k0_in;
      result_ff <= result_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_write) begin
         key_mem_ff[IDX_W'(req_bus.key_slot)] <= {req_bus.key_alpha, req_bus.key_blue,
                                                 req_bus.key_green, req_bus.key_red};
      end
      rd_data_ff <= key_mem_ff[addr_ff];
   end

   // The wrapped key is (time - loop_start) mod span + loop_start.
   kfr_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (dividend),
      .divisor   (span),
      .done      (rem_done),
      .remainder (rem_value)
   );

   kfr_blend u_blend (
      .clock  (clock),
      .reset  (reset),
      .start  (blend_start),
      .frac   (frac_ff),
      .key_lo (k0_ff),
      .key_hi (rd_data_ff),
      .done   (blend_done),
      .color  (blend_color)
   );

   // Output register: loaded from a finished item, emptied when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_color_ff  <= result_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_red   = rsp_color_ff[0*CH_W +: CH_W];
   assign rsp_bus.out_green = rsp_color_ff[1*CH_W +: CH_W];
   assign rsp_bus.out_blue  = rsp_color_ff[2*CH_W +: CH_W];
   assign rsp_bus.out_alpha = rsp_color_ff[3*CH_W +: CH_W];
   assign rsp_bus.status    = rsp_status_ff;

   `KFR_ASSERT_ON(a_error_is_black, clock, reset, (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_color_ff == '0))
   `KFR_ASSERT_ON(a_rem_done_in_divide, clock, reset, rem_done |-> (state_ff == S_DIVIDE))
   `KFR_ASSERT_ON(a_blend_done_in_blend, clock, reset, blend_done |-> (state_ff == S_BLEND))
   `KFR_ASSERT_NEXT(a_write_answers_black, clock, reset, req_accept && (req_bus.opcode == OP_WRITE), (state_ff == S_DONE) && (result_ff == '0) && (status_ff == ST_OK))

endmodule

/* design/kfr_rem.sv */
module kfr_rem (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [kfr_pkg::TIME_W-1:0]   dividend,
   input  logic [kfr_pkg::KEY_W-1:0]    divisor,
   output logic                         done,
   output logic [kfr_pkg::KEY_W-1:0]    remainder
);
   import kfr_pkg::*;

   // Restoring remainder: one dividend bit enters the partial remainder per cycle.
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0]    dvd_ff, dvd_in;
   logic [KEY_W-1:0]     dsr_ff, dsr_in;
   logic [KEY_W-1:0]     rem_ff, rem_in;
   logic [KEY_W:0]       trial;
   logic [KEY_W:0]       diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[TIME_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it fits in KEY_W bits.
         rem_in = (trial >= {1'b0, dsr_ff}) ? diff[KEY_W-1:0] : trial[KEY_W-1:0];
         dvd_in = {dvd_ff[TIME_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == REM_CNT_W'(REM_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* design/kfr_blend.sv */
module kfr_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kfr_pkg::CH_W-1:0]      frac,
   input  logic [kfr_pkg::COLOR_W-1:0]   key_lo,
   input  logic [kfr_pkg::COLOR_W-1:0]   key_hi,
   output logic                          done,
   output logic [kfr_pkg::COLOR_W-1:0]   color
);
   import kfr_pkg::*;

   // Bit-serial weighted sum, most significant weight bit first:
   // acc = f*key_hi + (256-f)*key_lo, one bit of each weight per cycle.
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [BLEND_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CH_W:0]          wf_ff, wf_in;
   logic [CH_W:0]          wg_ff, wg_in;
   logic [COLOR_W-1:0]     klo_ff, klo_in;
   logic [COLOR_W-1:0]     khi_ff, khi_in;
   logic [ACC_W-1:0]       acc_ff [NUM_CH];
   logic [ACC_W-1:0]       acc_in [NUM_CH];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      wf_in   = wf_ff;
      wg_in   = wg_ff;
      klo_in  = klo_ff;
      khi_in  = khi_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         acc_in[c] = acc_ff[c];
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         wf_in   = {1'b0, frac};
         wg_in   = {1'b1, {CH_W{1'b0}}} - {1'b0, frac};
         klo_in  = key_lo;
         khi_in  = key_hi;
         for (int c = 0; c < NUM_CH; c++) begin
            acc_in[c] = '0;
         end
      end else if (busy_ff) begin
         for (int c = 0; c < NUM_CH; c++) begin
            acc_in[c] = {acc_ff[c][ACC_W-2:0], 1'b0}
               + (wf_ff[CH_W] ? {{CH_W{1'b0}}, khi_ff[c*CH_W +: CH_W]} : '0)
               + (wg_ff[CH_W] ? {{CH_W{1'b0}}, klo_ff[c*CH_W +: CH_W]} : '0);
         end
         wf_in  = {wf_ff[CH_W-1:0], 1'b0};
         wg_in  = {wg_ff[CH_W-1:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == BLEND_CNT_W'(BLEND_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      wf_ff  <= wf_in;
      wg_ff  <= wg_in;
      klo_ff <= klo_in;
      khi_ff <= khi_in;
      for (int c = 0; c < NUM_CH; c++) begin
         acc_ff[c] <= acc_in[c];
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         color[c*CH_W +: CH_W] = acc_ff[c][ACC_W-1:CH_W];
      end
   end

   assign done = done_ff;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

// Self-checking bench for the keyframe color ramp. Key colors are written into
// the table and queried back by emitter time (wrapping or clamping) and by
// lifetime percent (blending two neighboring keys). Every accepted request
// word is run through a local color lookup that mirrors the ramp, and the
// color it computes waits in a queue until the block answers.
module testbench;
   import kfr_pkg::*;

   localparam int KEY_COUNT   = 128;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_COUNT = 12;
   localparam int PHASE_WORDS = 130;

   // One request word as the driver puts it on the bus.
   typedef struct packed {
      logic              opcode;
      logic [SLOT_W-1:0] key_slot;
      logic [CH_W-1:0]   key_red;
      logic [CH_W-1:0]   key_green;
      logic [CH_W-1:0]   key_blue;
      logic [CH_W-1:0]   key_alpha;
      logic [TIME_W-1:0] emitter_time;
      logic [PCT_W-1:0]  life_percent;
      logic [CH_W-1:0]   life_fraction;
   } key_request_type;

   // One response word: the looked-up color and its status.
   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] alpha;
      status_type      status;
   } color_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kfr_req_if req_bus ();
   kfr_rsp_if rsp_bus ();
   kfr_csr_if csr_bus ();

   keyframe_color_ramp #(
      .KEY_COUNT (KEY_COUNT)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Local copy of the register file, updated when a register write is taken.
   logic                 cfg_percent_mode = 1'b0;
   logic                 cfg_loop_enable  = 1'b0;
   logic [LSTART_W-1:0]  cfg_loop_start   = '0;
   logic [LEND_W-1:0]    cfg_loop_end     = LOOP_END_RESET;

   // The lookup keeps its own key table. The stimulus side keeps a separate
   // record of which slots hold a color, so that no query ever reads a key
   // that was never written.
   color_type   ramp_keys [KEY_COUNT];
   bit          key_written [KEY_COUNT];

   key_request_type  queued_requests [$];
   color_result_type pending_colors [$];

   int fail_count = 0;
   int cycle_count = 0;

   // ------------------------------------------------------------------------
   // Color lookup
   // ------------------------------------------------------------------------

   // Turns an emitter time into a key index under the current loop settings.
   // With looping on, a time at or past the loop end wraps into the span; an
   // empty span is an error. With looping off, the index clamps to the key
   // below the loop end, and a loop end of zero clamps it below the table.
   function automatic int time_key_index(input logic [TIME_W-1:0] t,
                                         output status_type st);
      int key;
      int span;
      key = int'(t);
      st  = ST_OK;
      if (cfg_loop_enable) begin
         if (t >= cfg_loop_end) begin
            span = int'(cfg_loop_end) - int'(cfg_loop_start);
            if (span <= 0) begin
               st = ST_EMPTY_SPAN;
               return -1;
            end
            key = (int'(t) - int'(cfg_loop_start)) % span + int'(cfg_loop_start);
         end
      end else if (int'(cfg_loop_end) - 1 < key) begin
         key = int'(cfg_loop_end) - 1;
      end
      if (key < 0 || key >= KEY_COUNT) begin
         st = ST_RANGE;
         return -1;
      end
      return key;
   endfunction

   // Computes the answer to one request word and applies key writes.
   function automatic color_result_type ramp_lookup(input key_request_type q);
      color_result_type r;
      color_type        color;
      status_type       st;
      int               key;
      int               pct;
      int               f;
      int               c0;
      int               c1;
      r     = '0;
      color = '0;
      pct   = int'(q.life_percent);
      f     = int'(q.life_fraction);
      if (q.opcode == OP_WRITE) begin
         // The slot field cannot address past the table, so every write lands.
         ramp_keys[q.key_slot] = {q.key_alpha, q.key_blue, q.key_green, q.key_red};
         return r;
      end
      if (!cfg_percent_mode) begin
         key = time_key_index(q.emitter_time, st);
         r.status = st;
         if (st == ST_OK)
            color = ramp_keys[key];
      end else if (q.life_percent == PCT_FULL) begin
         color = ramp_keys[int'(PCT_FULL)];
      end else if (pct + 1 >= KEY_COUNT) begin
         r.status = ST_RANGE;
      end else begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            c0 = int'(ramp_keys[pct][CH_W*ch +: CH_W]);
            c1 = int'(ramp_keys[pct + 1][CH_W*ch +: CH_W]);
            color[CH_W*ch +: CH_W] = CH_W'((f * c1 + (256 - f) * c0) >> 8);
         end
      end
      r.red   = color[7:0];
      r.green = color[15:8];
      r.blue  = color[23:16];
      r.alpha = color[31:24];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------

   // Each word is followed by a randomly drawn gap, except during bursts,
   // which switch on and off at random and leave no gaps at all.
   key_request_type req_word;
   int              req_gap_left = 0;
   bit              req_burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            pending_colors.push_back(ramp_lookup(req_word));
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_bus.valid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               req_word = queued_requests.pop_front();
               req_bus.opcode        <= req_word.opcode;
               req_bus.key_slot      <= req_word.key_slot;
               req_bus.key_red       <= req_word.key_red;
               req_bus.key_green     <= req_word.key_green;
               req_bus.key_blue      <= req_word.key_blue;
               req_bus.key_alpha     <= req_word.key_alpha;
               req_bus.emitter_time  <= req_word.emitter_time;
               req_bus.life_percent  <= req_word.life_percent;
               req_bus.life_fraction <= req_word.life_fraction;
               req_bus.valid         <= 1'b1;
               if ($urandom_range(0, 99) < 3)
                  req_burst = !req_burst;
               req_gap_left = req_burst ? 0 : $urandom_range(0, 3);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor
   // ------------------------------------------------------------------------

   // After each word taken, ready drops for a randomly drawn wait, except during
   // bursts. Twice in the run the receiver holds off for a long stretch so that
   // the output register and the result behind it fill up and the block stops taking requests.
   int               rsp_wait_left = 0;
   int               rsp_hold_left = 0;
   int               words_taken = 0;
   bit               rsp_burst = 1'b0;
   color_result_type seen_color;
   color_result_type want_color;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_color = '{rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue,
                           rsp_bus.out_alpha, rsp_bus.status};
            if (pending_colors.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected color word: r=%0d g=%0d b=%0d a=%0d st=%0d",
                           seen_color.red, seen_color.green, seen_color.blue,
                           seen_color.alpha, seen_color.status);
            end else begin
               want_color = pending_colors.pop_front();
               if (seen_color.red !== want_color.red
                   || seen_color.green !== want_color.green
                   || seen_color.blue !== want_color.blue
                   || seen_color.alpha !== want_color.alpha
                   || seen_color.status !== want_color.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"color mismatch at word %0d: ",
                               "expected r=%0d g=%0d b=%0d a=%0d st=%0d, ",
                               "got r=%0d g=%0d b=%0d a=%0d st=%0d"},
                              words_taken, want_color.red, want_color.green,
                              want_color.blue, want_color.alpha, want_color.status,
                              seen_color.red, seen_color.green, seen_color.blue,
                              seen_color.alpha, seen_color.status);
               end
            end
            words_taken++;
            if ($urandom_range(0, 99) < 3)
               rsp_burst = !rsp_burst;
            if (words_taken == 300 || words_taken == 1100)
               rsp_hold_left = 150;
            else
               rsp_wait_left = rsp_burst ? 0 : $urandom_range(0, 3);
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_wait_left > 0) begin
            rsp_wait_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // A run that stops making progress ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   function automatic logic [CH_W-1:0] random_channel();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return CH_W'($urandom);
      endcase
   endfunction

   // A query word with every other field random; callers then fix the fields that matter.
   function automatic key_request_type random_word();
      key_request_type q;
      q.opcode        = OP_QUERY;
      q.key_slot      = SLOT_W'($urandom);
      q.key_red       = CH_W'($urandom);
      q.key_green     = CH_W'($urandom);
      q.key_blue      = CH_W'($urandom);
      q.key_alpha     = CH_W'($urandom);
      q.emitter_time  = TIME_W'($urandom);
      q.life_percent  = PCT_W'($urandom_range(0, 100));
      q.life_fraction = CH_W'($urandom);
      return q;
   endfunction

   task automatic push_key_write(input int slot);
      key_request_type q;
      q = random_word();
      q.opcode    = OP_WRITE;
      q.key_slot  = SLOT_W'(slot);
      q.key_red   = random_channel();
      q.key_green = random_channel();
      q.key_blue  = random_channel();
      q.key_alpha = random_channel();
      key_written[slot] = 1'b1;
      queued_requests.push_back(q);
   endtask

   task automatic ensure_key(input int slot);
      if (!key_written[slot])
         push_key_write(slot);
   endtask

   // Queues a query after first writing any key it reads that holds no color.
   task automatic push_query(input key_request_type q);
      status_type st;
      int         key;
      if (!cfg_percent_mode) begin
         key = time_key_index(q.emitter_time, st);
         if (st == ST_OK)
            ensure_key(key);
      end else if (q.life_percent == PCT_FULL) begin
         ensure_key(int'(PCT_FULL));
      end else begin
         ensure_key(int'(q.life_percent));
         ensure_key(int'(q.life_percent) + 1);
      end
      queued_requests.push_back(q);
   endtask

   task automatic push_time_query(input logic [TIME_W-1:0] t);
      key_request_type q;
      q = random_word();
      q.emitter_time = t;
      push_query(q);
   endtask

   task automatic push_percent_query(input int pct, input int f);
      key_request_type q;
      q = random_word();
      q.life_percent  = PCT_W'(pct);
      q.life_fraction = CH_W'(f);
      push_query(q);
   endtask

   // Writes one register while the block is idle and mirrors it locally.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_PERCENT_MODE: cfg_percent_mode = value[0];
         CSR_LOOP_ENABLE:  cfg_loop_enable  = value[0];
         CSR_LOOP_START:   cfg_loop_start   = value[LSTART_W-1:0];
         CSR_LOOP_END:     cfg_loop_end     = value[LEND_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic pm, input logic le, input int ls,
                                 input int lend);
      write_reg(CSR_PERCENT_MODE, CSR_DATA_W'(pm));
      write_reg(CSR_LOOP_ENABLE, CSR_DATA_W'(le));
      write_reg(CSR_LOOP_START, CSR_DATA_W'(ls));
      write_reg(CSR_LOOP_END, CSR_DATA_W'(lend));
   endtask

   // Every request word yields one color word, so once nothing is queued,
   // nothing is on the bus and no color is outstanding, the block is idle.
   // The check runs on the falling edge, where the driver's updates from the
   // rising edge have all settled.
   task automatic wait_until_idle();
      while (queued_requests.size() != 0 || req_bus.valid
             || pending_colors.size() != 0)
         @(negedge clock);
   endtask

   // A random query under the settings of the current phase. Times cluster
   // around the loop end so that both sides of the wrap and clamp are hit.
   task automatic push_random_query();
      logic [TIME_W-1:0] t;
      int                pct;
      if (cfg_percent_mode) begin
         case ($urandom_range(0, 4))
            0:       pct = 100;
            1:       pct = 99;
            2:       pct = 0;
            default: pct = $urandom_range(0, 100);
         endcase
         push_percent_query(pct, int'(random_channel()));
      end else begin
         case ($urandom_range(0, 5))
            0:       t = TIME_W'(cfg_loop_end) + TIME_W'($urandom_range(0, 300));
            1:       t = TIME_W'($urandom);
            2:       t = '1;
            3:       t = (cfg_loop_end == 0) ? '0 : TIME_W'(cfg_loop_end) - 1'b1;
            default: t = TIME_W'($urandom_range(0, 140));
         endcase
         push_time_query(t);
      end
   endtask

   initial begin
      int sel;
      int ls;
      int lend;

      req_bus.valid         = 1'b0;
      req_bus.opcode        = OP_WRITE;
      req_bus.key_slot      = '0;
      req_bus.key_red       = '0;
      req_bus.key_green     = '0;
      req_bus.key_blue      = '0;
      req_bus.key_alpha     = '0;
      req_bus.emitter_time  = '0;
      req_bus.life_percent  = '0;
      req_bus.life_fraction = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = CSR_PERCENT_MODE;
      csr_bus.data          = '0;
      foreach (key_written[i])
         key_written[i] = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Key writes at both ends of the table.
      push_key_write(0);
      push_key_write(127);
      push_key_write(100);

      // Reset settings clamp every time to key zero.
      push_time_query('0);
      push_time_query('1);
      wait_until_idle();

      // A loop end of zero clamps below the table.
      apply_settings(1'b0, 1'b0, 0, 0);
      push_time_query(TIME_W'(5));
      wait_until_idle();

      // An empty loop span; a time under the loop end still indexes directly.
      apply_settings(1'b0, 1'b1, 10, 10);
      push_time_query(TIME_W'(10));
      push_time_query(TIME_W'(3));
      wait_until_idle();

      // A one-key span at the top of the table and the widest span.
      apply_settings(1'b0, 1'b1, 127, 128);
      push_time_query('1);
      push_time_query(TIME_W'(127));
      push_time_query(TIME_W'(200));
      wait_until_idle();
      apply_settings(1'b0, 1'b1, 0, 128);
      push_time_query('1);
      push_time_query(TIME_W'(1000));
      wait_until_idle();

      // Percent blending: the full lifetime picks key 100 directly, the rest
      // blend with fractions at and between the extremes.
      apply_settings(1'b1, 1'b0, 0, 1);
      push_percent_query(100, 37);
      push_percent_query(0, 0);
      push_percent_query(0, 255);
      push_percent_query(99, 128);
      push_percent_query(50, 1);
      push_percent_query(64, 200);
      wait_until_idle();

      // Random phases, each under its own settings. Most spans are well formed;
      // the rest are empty, extreme or drawn at random.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         sel = $urandom_range(0, 9);
         if (sel < 6) begin
            lend = $urandom_range(1, 128);
            ls   = $urandom_range(0, lend - 1);
         end else begin
            case (sel)
               6: begin ls = 0;   lend = 0;   end
               7: begin ls = 127; lend = 128; end
               8: begin ls = $urandom_range(0, 127); lend = $urandom_range(0, 128); end
               default: begin ls = 0; lend = 128; end
            endcase
         end
         apply_settings(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                        ls, lend);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 99) < 25)
               push_key_write($urandom_range(0, KEY_COUNT - 1));
            else
               push_random_query();
         end
         wait_until_idle();
      end

      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
